>>> hw/rtl/hrs_pkg.sv
// shared types, character constants and pattern lookups for the http response header scanner
`default_nettype none

package hrs_pkg;

    // per-byte control from the top level into the matchers
    typedef struct packed {
        logic upd;  // item carries a live text byte: advance the matcher
        logic clr;  // item ends the response: return to reset state
    } step_ctl_t;

    // characters
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CH_NUL   = 8'h00;

    // status line geometry
    localparam logic [3:0] STATUS_FIRST   = 4'd9;
    localparam logic [3:0] STATUS_LAST    = 4'd11;
    localparam logic [3:0] STATUS_MIN_LEN = 4'd12;

    // header patterns
    localparam logic [4:0] AUTH_LEN   = 5'd17;
    localparam logic [3:0] SERVER_LEN = 4'd8;
    localparam logic [8*17-1:0] AUTH_STR   = "WWW-AUTHENTICATE:";
    localparam logic [8*8-1:0]  SERVER_STR = "\nServer:";

    // scheme names, upper case, zero padded
    localparam logic [7:0] SCHEME_PAT [3][8] = '{
        '{8'h42, 8'h41, 8'h53, 8'h49, 8'h43, 8'h00, 8'h00, 8'h00},  // BASIC
        '{8'h44, 8'h49, 8'h47, 8'h45, 8'h53, 8'h54, 8'h00, 8'h00},  // DIGEST
        '{8'h4E, 8'h54, 8'h4C, 8'h4D, 8'h00, 8'h00, 8'h00, 8'h00}   // NTLM
    };
    localparam logic [2:0] SCHEME_LEN [3] = '{3'd5, 3'd6, 3'd4};

    // ascii upper case
    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z)
        begin
            r = c - 8'd32;
        end
        return r;
    endfunction

    // character i of the auth header name, zero past the end
    function automatic logic [7:0] auth_char(input logic [4:0] i);
        logic [7:0] r;
        int         p;
        r = CH_NUL;
        p = int'(AUTH_LEN) - 1 - int'(i);
        if (i < AUTH_LEN)
        begin
            r = AUTH_STR[8*p +: 8];
        end
        return r;
    endfunction

    // character i of the server header name, zero past the end
    function automatic logic [7:0] server_char(input logic [3:0] i);
        logic [7:0] r;
        int         p;
        r = CH_NUL;
        p = int'(SERVER_LEN) - 1 - int'(i);
        if (i < SERVER_LEN)
        begin
            r = SERVER_STR[8*p +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/hrs_status.sv
// status code extraction from bytes 9 to 11 of the response
`default_nettype none

module hrs_status (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrs_pkg::step_ctl_t ctl,
    input  wire logic [7:0]        text_byte,
    output logic [9:0]             code_next
);

    logic [3:0] pos_reg, pos_next;
    logic       h_reg, h_next;
    logic [9:0] acc_reg, acc_next;
    logic       stopped_reg, stopped_next;
    logic       started_reg, started_next;
    logic       is_digit, is_space;

    assign is_digit = (text_byte >= hrs_pkg::CH_ZERO) && (text_byte <= hrs_pkg::CH_NINE);
    assign is_space = (text_byte == hrs_pkg::CH_SPACE) ||
                      ((text_byte >= hrs_pkg::CH_TAB) && (text_byte <= hrs_pkg::CH_CR));

    // atoi-style digit accumulation over the status window
    always_comb
    begin
        pos_next     = pos_reg;
        h_next       = h_reg;
        acc_next     = acc_reg;
        stopped_next = stopped_reg;
        started_next = started_reg;
        if (ctl.upd)
        begin
            if (pos_reg == 4'd0)
            begin
                h_next = (text_byte == hrs_pkg::CH_H);
            end
            if (pos_reg >= hrs_pkg::STATUS_FIRST && pos_reg <= hrs_pkg::STATUS_LAST &&
                !stopped_reg)
            begin
                priority if (is_digit)
                begin
                    acc_next = {acc_reg[6:0], 3'b000} + {acc_reg[8:0], 1'b0} +
                               {6'd0, text_byte[3:0]};
                    started_next = 1'b1;
                end
                else if (!started_reg && is_space)
                begin
                    started_next = 1'b0;
                end
                else if (!started_reg && text_byte == hrs_pkg::CH_PLUS)
                begin
                    started_next = 1'b1;
                end
                else
                begin
                    stopped_next = 1'b1;
                end
            end
            if (pos_reg < hrs_pkg::STATUS_MIN_LEN)
            begin
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    // status is reported only for long enough text that starts with H
    assign code_next = (h_next && pos_next >= hrs_pkg::STATUS_MIN_LEN) ? acc_next : 10'd0;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= 4'd0;
            h_reg       <= 1'b0;
            acc_reg     <= 10'd0;
            stopped_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            pos_reg     <= 4'd0;
            h_reg       <= 1'b0;
            acc_reg     <= 10'd0;
            stopped_reg <= 1'b0;
            started_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            h_reg       <= h_next;
            acc_reg     <= acc_next;
            stopped_reg <= stopped_next;
            started_reg <= started_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hrs_auth.sv
// www-authenticate header matcher and challenge scheme flags
`default_nettype none

module hrs_auth (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrs_pkg::step_ctl_t ctl,
    input  wire logic [7:0]        text_byte,
    output logic [2:0]             flags_next
);

    typedef enum logic [2:0] {
        SP_IDLE  = 3'b001,
        SP_SKIP  = 3'b010,
        SP_MATCH = 3'b100
    } scheme_phase_t;

    scheme_phase_t ph_reg, ph_next;
    logic [4:0]    aidx_reg, aidx_next;
    logic [2:0]    sidx_reg, sidx_next;
    logic [2:0]    cand_reg, cand_next;
    logic [2:0]    flags_reg;
    logic [7:0]    u;
    logic          go;

    assign u = hrs_pkg::upcase(text_byte);

    // scheme match on the old state, then header-name match may restart it
    always_comb
    begin
        ph_next    = ph_reg;
        aidx_next  = aidx_reg;
        sidx_next  = sidx_reg;
        cand_next  = cand_reg;
        flags_next = flags_reg;
        go         = 1'b1;
        if (ctl.upd)
        begin
            // skip spaces before the scheme name
            if (ph_next == SP_SKIP)
            begin
                if (u == hrs_pkg::CH_SPACE)
                begin
                    go = 1'b0;
                end
                else
                begin
                    ph_next   = SP_MATCH;
                    sidx_next = 3'd0;
                end
            end
            // compare against all live scheme names in parallel
            if (go && ph_next == SP_MATCH)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (cand_next[k])
                    begin
                        if (sidx_next >= hrs_pkg::SCHEME_LEN[k] ||
                            u != hrs_pkg::SCHEME_PAT[k][sidx_next])
                        begin
                            cand_next[k] = 1'b0;
                        end
                        else if (sidx_next + 3'd1 == hrs_pkg::SCHEME_LEN[k])
                        begin
                            flags_next[k] = 1'b1;
                            cand_next[k]  = 1'b0;
                        end
                    end
                end
                sidx_next = sidx_next + 3'd1;
                if (cand_next == 3'b000)
                begin
                    ph_next = SP_IDLE;
                end
            end
            // header name match
            if (aidx_reg < hrs_pkg::AUTH_LEN && u == hrs_pkg::auth_char(aidx_reg))
            begin
                if (aidx_reg + 5'd1 == hrs_pkg::AUTH_LEN)
                begin
                    aidx_next = 5'd0;
                    ph_next   = SP_SKIP;
                    cand_next = 3'b111;
                    sidx_next = 3'd0;
                end
                else
                begin
                    aidx_next = aidx_reg + 5'd1;
                end
            end
            else if (u == hrs_pkg::CH_W)
            begin
                aidx_next = (aidx_reg == 5'd3) ? 5'd3 : 5'd1;
            end
            else
            begin
                aidx_next = 5'd0;
            end
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg    <= SP_IDLE;
            aidx_reg  <= 5'd0;
            sidx_reg  <= 3'd0;
            cand_reg  <= 3'b111;
            flags_reg <= 3'b000;
        end
        else if (ctl.clr)
        begin
            ph_reg    <= SP_IDLE;
            aidx_reg  <= 5'd0;
            sidx_reg  <= 3'd0;
            cand_reg  <= 3'b111;
            flags_reg <= 3'b000;
        end
        else
        begin
            ph_reg    <= ph_next;
            aidx_reg  <= aidx_next;
            sidx_reg  <= sidx_next;
            cand_reg  <= cand_next;
            flags_reg <= flags_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hrs_banner.sv
// server header matcher and banner pass-through
`default_nettype none

module hrs_banner (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hrs_pkg::step_ctl_t ctl,
    input  wire logic [7:0]        text_byte,
    input  wire logic [7:0]        banner_limit,
    output logic                   pass_next,
    output logic                   found_next
);

    typedef enum logic [3:0] {
        BP_SEARCH = 4'b0001,
        BP_SKIP   = 4'b0010,
        BP_PASS   = 4'b0100,
        BP_FIN    = 4'b1000
    } banner_phase_t;

    banner_phase_t ph_reg, ph_next;
    logic [3:0]    sidx_reg, sidx_next;
    logic [7:0]    cnt_reg, cnt_next;

    // search, skip spaces, pass bytes up to line end or the limit
    always_comb
    begin
        ph_next   = ph_reg;
        sidx_next = sidx_reg;
        cnt_next  = cnt_reg;
        pass_next = 1'b0;
        if (ctl.upd)
        begin
            if (ph_reg == BP_SEARCH)
            begin
                if (sidx_reg < hrs_pkg::SERVER_LEN &&
                    text_byte == hrs_pkg::server_char(sidx_reg))
                begin
                    sidx_next = sidx_reg + 4'd1;
                    if (sidx_reg + 4'd1 == hrs_pkg::SERVER_LEN)
                    begin
                        ph_next = BP_SKIP;
                    end
                end
                else
                begin
                    sidx_next = (text_byte == hrs_pkg::CH_LF) ? 4'd1 : 4'd0;
                end
            end
            else
            begin
                if (ph_reg == BP_SKIP && text_byte != hrs_pkg::CH_SPACE)
                begin
                    ph_next = BP_PASS;
                end
                if (ph_next == BP_PASS)
                begin
                    if (text_byte == hrs_pkg::CH_CR || text_byte == hrs_pkg::CH_LF ||
                        cnt_reg >= banner_limit)
                    begin
                        ph_next = BP_FIN;
                    end
                    else
                    begin
                        cnt_next  = cnt_reg + 8'd1;
                        pass_next = 1'b1;
                    end
                end
            end
        end
    end

    assign found_next = (ph_next != BP_SEARCH);

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ph_reg   <= BP_SEARCH;
            sidx_reg <= 4'd0;
            cnt_reg  <= 8'd0;
        end
        else if (ctl.clr)
        begin
            ph_reg   <= BP_SEARCH;
            sidx_reg <= 4'd0;
            cnt_reg  <= 8'd0;
        end
        else
        begin
            ph_reg   <= ph_next;
            sidx_reg <= sidx_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/http_response_header_scanner.sv
// top level of the http response header scanner: input stage, matchers, result stage
//
// Usage: feed the response one byte per item on in_valid/in_ready with text_byte and
// last_byte; last_byte marks the final byte. Every input item yields exactly one result
// item on out_valid/out_ready. banner_valid/banner_byte pass the server banner bytes
// through as they arrive; done_res is set on the result of the last byte, and only then
// are status_code, challenge_flags and server_found meaningful (zero otherwise).
// A zero text byte ends the text; later bytes up to last_byte change nothing.
// The user writes banner_limit (reset 63) via cfg_we/cfg_data only while the block
// is idle; the block itself does not enforce it. An item is held in the input
// register, then its result in the result register. Throughput: one item per cycle
// while the receiver accepts; per-byte matcher updates are combinational in between.
// When the receiver stalls, the result register holds and the input register still
// takes one more item; after that in_ready drops until a result leaves.
// Reset clears both stages and all matcher state and loads banner_limit with 63; after
// each last byte the matchers return to reset state for the next response.
`default_nettype none

module http_response_header_scanner (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_we,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] text_byte,
    input  wire logic       last_byte,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic            banner_valid,
    output logic [7:0]      banner_byte,
    output logic            done_res,
    output logic [9:0]      status_code,
    output logic [2:0]      challenge_flags,
    output logic            server_found
);

    localparam logic [7:0] BANNER_LIMIT_RESET = 8'd63;

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_last_reg;
    logic               text_ended_reg;
    logic [7:0]         limit_reg;
    logic               out_valid_reg;
    logic               bvalid_reg;
    logic [7:0]         bbyte_reg;
    logic               done_reg;
    logic [9:0]         status_reg;
    logic [2:0]         flags_reg;
    logic               found_reg;
    logic               adv;
    logic               take;
    logic               live;
    hrs_pkg::step_ctl_t ctl;
    logic [9:0]         code_next;
    logic [2:0]         flags_next;
    logic               pass_next;
    logic               found_next;

    // handshake: result stage moves when empty or drained
    assign adv      = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || adv;
    assign take     = in_valid && in_ready;
    assign live     = !text_ended_reg && (s1_byte_reg != hrs_pkg::CH_NUL);
    assign ctl      = '{upd: adv && live, clr: adv && s1_last_reg};

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= BANNER_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_byte_reg <= text_byte;
            s1_last_reg <= last_byte;
        end
    end

    // end-of-text marker from a zero byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_ended_reg <= 1'b0;
        end
        else if (ctl.clr)
        begin
            text_ended_reg <= 1'b0;
        end
        else if (adv && s1_byte_reg == hrs_pkg::CH_NUL)
        begin
            text_ended_reg <= 1'b1;
        end
    end

    hrs_status u_status (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .text_byte (s1_byte_reg),
        .code_next (code_next)
    );

    hrs_auth u_auth (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .text_byte  (s1_byte_reg),
        .flags_next (flags_next)
    );

    hrs_banner u_banner (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .text_byte    (s1_byte_reg),
        .banner_limit (limit_reg),
        .pass_next    (pass_next),
        .found_next   (found_next)
    );

    // result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            bvalid_reg <= pass_next;
            bbyte_reg  <= pass_next ? s1_byte_reg : 8'd0;
            done_reg   <= s1_last_reg;
            status_reg <= s1_last_reg ? code_next : 10'd0;
            flags_reg  <= s1_last_reg ? flags_next : 3'd0;
            found_reg  <= s1_last_reg && found_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign banner_valid    = bvalid_reg;
    assign banner_byte     = bbyte_reg;
    assign done_res        = done_reg;
    assign status_code     = status_reg;
    assign challenge_flags = flags_reg;
    assign server_found    = found_reg;

    // summary fields only on the final result
    a_summary_only_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !done_res) |->
            (status_code == 10'd0 && challenge_flags == 3'd0 && !server_found))
        else $error("summary fields set on a non-final result");

    // banner bytes are never line ends or the terminator
    a_banner_byte_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && banner_valid) |->
            (banner_byte != hrs_pkg::CH_CR && banner_byte != hrs_pkg::CH_LF &&
             banner_byte != hrs_pkg::CH_NUL))
        else $error("illegal banner byte passed");

    // back-pressure only when the input stage is occupied and cannot move
    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled without cause");

    // the end of a response re-arms the zero-byte marker
    a_end_rearms: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s1_last_reg) |=> !text_ended_reg)
        else $error("text end marker survived the last byte");

endmodule

`default_nettype wire

>>> bench/tb_http_response_header_scanner.sv
// testbench for the http response header scanner: directed responses, then random traffic
`default_nettype none

module tb_http_response_header_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_BYTES = 260;
    localparam logic [4:0] WWW_RUN = 5'd3;

    // header names as the scanner matches them
    localparam logic [8*17-1:0] AUTH_NAME   = "WWW-AUTHENTICATE:";
    localparam logic [8*8-1:0]  SERVER_NAME = "\nServer:";

    typedef enum logic [1:0] {SCH_IDLE, SCH_SKIP, SCH_MATCH} sch_phase_t;
    typedef enum logic [1:0] {BAN_SEARCH, BAN_SKIP, BAN_PASS, BAN_DONE} ban_phase_t;

    typedef struct packed {
        logic       banner_valid;
        logic [7:0] banner_byte;
        logic       done;
        logic [9:0] status;
        logic [2:0] flags;
        logic       server;
    } scan_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [7:0] cfg_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] text_byte = 8'd0;
    logic       last_byte = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic       banner_valid;
    logic [7:0] banner_byte;
    logic       done_res;
    logic [9:0] status_code;
    logic [2:0] challenge_flags;
    logic       server_found;

    http_response_header_scanner u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .text_byte       (text_byte),
        .last_byte       (last_byte),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .banner_valid    (banner_valid),
        .banner_byte     (banner_byte),
        .done_res        (done_res),
        .status_code     (status_code),
        .challenge_flags (challenge_flags),
        .server_found    (server_found)
    );

    // scanner state as predicted
    logic [7:0]    ban_limit;
    logic [3:0]    pos;
    logic          lead_h;
    logic [9:0]    stat_acc;
    logic          stat_stop;
    logic          stat_begun;
    logic [4:0]    auth_idx;
    sch_phase_t    sch_phase;
    logic [2:0]    sch_idx;
    logic [2:0]    sch_cand;
    logic [2:0]    flag_bits;
    logic [3:0]    srv_idx;
    ban_phase_t    ban_phase;
    logic [7:0]    ban_cnt;
    logic          ended;

    scan_result_t expected_q[$];
    scan_result_t want_res;
    logic [7:0]   resp_text[$];
    int           errors = 0;
    int           bytes_sent = 0;
    int           burst_left = 0;
    int           cycle_count = 0;
    logic [7:0]   ready_mask = 8'hFF;
    logic [4:0]   ready_phase = 5'd0;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_http_response_header_scanner: done, errors");
        $finish;
    end

    // scanner state back to start of a response
    function automatic void clear_scan();
        pos        = '0;
        lead_h     = 1'b0;
        stat_acc   = '0;
        stat_stop  = 1'b0;
        stat_begun = 1'b0;
        auth_idx   = '0;
        sch_phase  = SCH_IDLE;
        sch_idx    = '0;
        sch_cand   = 3'b111;
        flag_bits  = '0;
        srv_idx    = '0;
        ban_phase  = BAN_SEARCH;
        ban_cnt    = '0;
        ended      = 1'b0;
    endfunction

    // letter i of scheme k (basic, digest, ntlm), zero past the end
    function automatic logic [7:0] scheme_char(input int k, input int i);
        logic [47:0] name;
        int          n;
        case (k)
            0:
            begin
                name = {"BASIC", hrs_pkg::CH_NUL};
                n = 5;
            end
            1:
            begin
                name = "DIGEST";
                n = 6;
            end
            default:
            begin
                name = {"NTLM", hrs_pkg::CH_NUL, hrs_pkg::CH_NUL};
                n = 4;
            end
        endcase
        scheme_char = hrs_pkg::CH_NUL;
        if (i < n)
        begin
            scheme_char = name[8*(5-i) +: 8];
        end
    endfunction

    // advance the predicted scanner by one byte and return its result item
    function automatic scan_result_t predict_scan(input logic [7:0] c, input logic l);
        scan_result_t r;
        logic [7:0]   u;
        logic [7:0]   lt;
        r = '0;
        if (!ended)
        begin
            if (c == hrs_pkg::CH_NUL)
            begin
                ended = 1'b1;
            end
            else
            begin
                u = (c >= hrs_pkg::CH_LOW_A && c <= hrs_pkg::CH_LOW_Z) ? c - 8'd32 : c;
                if (pos == 4'd0)
                begin
                    lead_h = (c == hrs_pkg::CH_H);
                end

                // status digits, atoi style
                if (pos >= hrs_pkg::STATUS_FIRST && pos <= hrs_pkg::STATUS_LAST && !stat_stop)
                begin
                    if (c >= hrs_pkg::CH_ZERO && c <= hrs_pkg::CH_NINE)
                    begin
                        stat_acc = 10'(int'(stat_acc) * 10 + int'(c - hrs_pkg::CH_ZERO));
                        stat_begun = 1'b1;
                    end
                    else if (!stat_begun && (c == hrs_pkg::CH_SPACE ||
                             (c >= hrs_pkg::CH_TAB && c <= hrs_pkg::CH_CR)))
                    begin
                        stat_stop = 1'b0;
                    end
                    else if (!stat_begun && c == hrs_pkg::CH_PLUS)
                    begin
                        stat_begun = 1'b1;
                    end
                    else
                    begin
                        stat_stop = 1'b1;
                    end
                end
                if (pos < hrs_pkg::STATUS_MIN_LEN)
                begin
                    pos++;
                end

                // scheme names after an auth header
                if (sch_phase == SCH_SKIP && u != hrs_pkg::CH_SPACE)
                begin
                    sch_phase = SCH_MATCH;
                    sch_idx = '0;
                end
                if (sch_phase == SCH_MATCH)
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        if (sch_cand[k])
                        begin
                            lt = scheme_char(k, int'(sch_idx));
                            if (lt == hrs_pkg::CH_NUL || u != lt)
                            begin
                                sch_cand[k] = 1'b0;
                            end
                            else if (scheme_char(k, int'(sch_idx) + 1) == hrs_pkg::CH_NUL)
                            begin
                                flag_bits[k] = 1'b1;
                                sch_cand[k] = 1'b0;
                            end
                        end
                    end
                    sch_idx = sch_idx + 3'd1;
                    if (sch_cand == 3'b000)
                    begin
                        sch_phase = SCH_IDLE;
                    end
                end

                // auth header name, case-insensitive
                if (auth_idx < hrs_pkg::AUTH_LEN &&
                    u == AUTH_NAME[8*(16-int'(auth_idx)) +: 8])
                begin
                    auth_idx++;
                    if (auth_idx == hrs_pkg::AUTH_LEN)
                    begin
                        auth_idx = '0;
                        sch_phase = SCH_SKIP;
                        sch_cand = 3'b111;
                        sch_idx = '0;
                    end
                end
                else if (u == hrs_pkg::CH_W)
                begin
                    auth_idx = (auth_idx == WWW_RUN) ? WWW_RUN : 5'd1;
                end
                else
                begin
                    auth_idx = '0;
                end

                // server header and banner pass-through
                if (ban_phase == BAN_SEARCH)
                begin
                    if (srv_idx < hrs_pkg::SERVER_LEN &&
                        c == SERVER_NAME[8*(7-int'(srv_idx)) +: 8])
                    begin
                        srv_idx++;
                        if (srv_idx == hrs_pkg::SERVER_LEN)
                        begin
                            ban_phase = BAN_SKIP;
                        end
                    end
                    else
                    begin
                        srv_idx = (c == hrs_pkg::CH_LF) ? 4'd1 : 4'd0;
                    end
                end
                else
                begin
                    if (ban_phase == BAN_SKIP && c != hrs_pkg::CH_SPACE)
                    begin
                        ban_phase = BAN_PASS;
                    end
                    if (ban_phase == BAN_PASS)
                    begin
                        if (c == hrs_pkg::CH_CR || c == hrs_pkg::CH_LF || ban_cnt >= ban_limit)
                        begin
                            ban_phase = BAN_DONE;
                        end
                        else
                        begin
                            ban_cnt++;
                            r.banner_valid = 1'b1;
                            r.banner_byte = c;
                        end
                    end
                end
            end
        end

        r.done = l;
        if (l)
        begin
            if (lead_h && pos >= hrs_pkg::STATUS_MIN_LEN)
            begin
                r.status = stat_acc;
            end
            r.flags = flag_bits;
            r.server = (ban_phase != BAN_SEARCH);
            clear_scan();
        end
        return r;
    endfunction

    // receiver stall pattern, reloaded each time ready_phase wraps to zero
    always @(posedge clk)
    begin
        if (ready_phase == 5'd0)
        begin
            case ($urandom_range(0, 3))
                0: ready_mask = 8'hFF;
                1: ready_mask = 8'($urandom) | 8'h01;
                2: ready_mask = 8'h01;
                default: ready_mask = 8'hF0;
            endcase
        end
        out_ready <= ready_mask[ready_phase[2:0]];
        ready_phase = ready_phase + 5'd1;
    end

    // compare each result item with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result item with nothing pending");
                errors++;
            end
            else
            begin
                want_res = expected_q.pop_front();
                if (banner_valid !== want_res.banner_valid)
                begin
                    $error("banner_valid: expected %0d, got %0d",
                           want_res.banner_valid, banner_valid);
                    errors++;
                end
                if (banner_byte !== want_res.banner_byte)
                begin
                    $error("banner_byte: expected %0d, got %0d",
                           want_res.banner_byte, banner_byte);
                    errors++;
                end
                if (done_res !== want_res.done)
                begin
                    $error("done_res: expected %0d, got %0d", want_res.done, done_res);
                    errors++;
                end
                if (status_code !== want_res.status)
                begin
                    $error("status_code: expected %0d, got %0d", want_res.status, status_code);
                    errors++;
                end
                if (challenge_flags !== want_res.flags)
                begin
                    $error("challenge_flags: expected %0d, got %0d",
                           want_res.flags, challenge_flags);
                    errors++;
                end
                if (server_found !== want_res.server)
                begin
                    $error("server_found: expected %0d, got %0d", want_res.server, server_found);
                    errors++;
                end
            end
        end
    end

    // one item in, sender gaps between bursts
    task automatic send_byte(input logic [7:0] c, input logic l);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid  <= 1'b1;
        text_byte <= c;
        last_byte <= l;
        expected_q.push_back(predict_scan(c, l));
        bytes_sent++;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // send the assembled response, last flag on its final byte
    task automatic send_response();
        foreach (resp_text[i])
        begin
            send_byte(resp_text[i], i == resp_text.size() - 1);
        end
        resp_text.delete();
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            resp_text.push_back(s[i]);
        end
    endtask

    // append with random letter case
    task automatic add_mixed(input string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            if (ch >= hrs_pkg::CH_LOW_A && ch <= hrs_pkg::CH_LOW_Z && $urandom_range(0, 1) == 1)
            begin
                ch = ch - 8'd32;
            end
            else if (ch >= "A" && ch <= "Z" && $urandom_range(0, 1) == 1)
            begin
                ch = ch + 8'd32;
            end
            resp_text.push_back(ch);
        end
    endtask

    // wait until every item has come back out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_banner_limit(input logic [7:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        ban_limit = v;
    endtask

    // status line: lengths, leading H, signs, whitespace ("\015" is carriage return)
    task automatic test_status_line();
        add_str("HTTP/1.1 200 OK\015\n");
        send_response();
        add_str("HTTP/1.0 404");
        send_response();
        add_str("HTTP/1.1 99");
        send_response();
        add_str("xTTP/1.1 301 Moved");
        send_response();
        add_str("HTTP/1.1 +42x");
        send_response();
        add_str("HTTP/1.1 -17");
        send_response();
        add_str("HTTP/1.1 \t 7 OK");
        send_response();
        add_str("HTTP/1.1 2x5");
        send_response();
        add_str("HTTP/1.1 999 Z");
        send_response();
        add_str("H");
        send_response();
    endtask

    // auth challenges: all schemes, repeats, overlaps, text ending inside a name
    task automatic test_auth_challenges();
        add_str("HTTP/1.1 401 No\015\nwww-authenticate:   basic realm=x\015\n");
        add_str("WWW-Authenticate: Digest q\015\nWww-Authenticate:NTLM\015\n\015\n");
        send_response();
        add_str("HTTP/1.1 401 a\015\nWWW-Authenticate: Basic\015\nWWW-Authenticate: basic\015\n");
        send_response();
        add_str("HTTP/1.1 401 b\015\nWWW-Authenticate: dige");
        send_response();
        add_str("HTTP/1.1 401 c\015\nWWW-Authenticate: Ba");
        resp_text.push_back(hrs_pkg::CH_NUL);
        add_str("sic\015\n");
        send_response();
        add_str("WWWWW-Authenticate: NTLMx\015\nWWW-WWW-Authenticate: digest");
        send_response();
    endtask

    // server banner: spaces, case, repeats, byte extremes, limit extremes
    task automatic test_server_banner();
        add_str("HTTP/1.1 200 OK\015\nServer:   demo-srv/1.0 (unix)\015\nDate: x\015\n");
        send_response();
        add_str("HTTP/1.1 200 OK\nserver: lower\n\nServer: a\nServer: b\n");
        send_response();
        add_str("HTTP/1.1 200 OK\nServer: ");
        resp_text.push_back(8'h80);
        resp_text.push_back(8'hFF);
        resp_text.push_back(8'h01);
        resp_text.push_back(8'h7F);
        resp_text.push_back(8'h55);
        resp_text.push_back(8'hAA);
        send_response();
        set_banner_limit(8'd1);
        add_str("HTTP/1.1 200 OK\015\nServer: cut-here\015\n");
        send_response();
        set_banner_limit(8'd255);
        add_str("HTTP/1.1 200 OK\015\nServer: ");
        repeat (270) resp_text.push_back(8'($urandom_range(33, 126)));
        add_str("\015\n");
        send_response();
        set_banner_limit(8'd0);
        add_str("HTTP/1.1 204 OK\015\nServer: none\015\n");
        send_response();
        set_banner_limit(8'd63);
    endtask

    // zero byte ends the text
    task automatic test_zero_byte();
        add_str("HTTP/1.1 200");
        resp_text.push_back(hrs_pkg::CH_NUL);
        add_str("\nServer: x\015\nWWW-Authenticate: basic");
        send_response();
        add_str("HTTP/1.1 20");
        resp_text.push_back(hrs_pkg::CH_NUL);
        add_str("0 more");
        send_response();
        resp_text.push_back(hrs_pkg::CH_NUL);
        send_response();
    endtask

    // random responses, mostly well formed, banner limit changed between them
    task automatic test_random_traffic();
        int         stop_at;
        int         resp_n;
        int         n;
        logic [7:0] ch;
        stop_at = bytes_sent + RANDOM_BYTES;
        resp_n = 0;
        while (bytes_sent < stop_at)
        begin
            if (resp_n % 6 == 5)
            begin
                case ($urandom_range(0, 5))
                    0: set_banner_limit(8'd1);
                    1: set_banner_limit(8'd255);
                    2: set_banner_limit(8'd0);
                    3: set_banner_limit(8'd63);
                    default: set_banner_limit(8'($urandom_range(1, 40)));
                endcase
            end

            // status line
            n = $urandom_range(0, 99);
            if (n < 80)
            begin
                add_str("HTTP/1.1 ");
                for (int i = 0; i < 3; i++)
                begin
                    if ($urandom_range(0, 9) < 7)
                    begin
                        resp_text.push_back(8'(hrs_pkg::CH_ZERO + $urandom_range(0, 9)));
                    end
                    else
                    begin
                        case ($urandom_range(0, 4))
                            0: resp_text.push_back(hrs_pkg::CH_SPACE);
                            1: resp_text.push_back(hrs_pkg::CH_PLUS);
                            2: resp_text.push_back("-");
                            3: resp_text.push_back(hrs_pkg::CH_TAB);
                            default:
                                resp_text.push_back(8'(hrs_pkg::CH_ZERO + $urandom_range(0, 9)));
                        endcase
                    end
                end
                add_str(" OK\015\n");
            end
            else if (n < 88)
            begin
                repeat ($urandom_range(1, 15)) resp_text.push_back(8'($urandom_range(1, 255)));
            end
            else if (n < 94)
            begin
                add_mixed("http/1.1 200 OK\015\n");
            end
            else
            begin
                add_str("HTTP/1.1 ");
                repeat ($urandom_range(0, 2))
                    resp_text.push_back(8'(hrs_pkg::CH_ZERO + $urandom_range(0, 9)));
            end

            // header lines
            repeat ($urandom_range(0, 4))
            begin
                case ($urandom_range(0, 5))
                    0, 1:
                    begin
                        add_mixed("WWW-Authenticate:");
                        repeat ($urandom_range(0, 3)) resp_text.push_back(hrs_pkg::CH_SPACE);
                        case ($urandom_range(0, 5))
                            0: add_mixed("basic");
                            1: add_mixed("digest");
                            2: add_mixed("ntlm");
                            3: add_mixed("dig");
                            4: add_mixed("bas1c");
                            default: add_mixed("ntl");
                        endcase
                        if ($urandom_range(0, 1) == 1)
                        begin
                            add_str(" realm=\"r\"");
                        end
                        add_str("\015\n");
                    end
                    2:
                    begin
                        case ($urandom_range(0, 6))
                            0: add_str("server:");
                            1: add_str("SERVER:");
                            default: add_str("Server:");
                        endcase
                        repeat ($urandom_range(0, 3)) resp_text.push_back(hrs_pkg::CH_SPACE);
                        n = ($urandom_range(0, 19) == 0) ? $urandom_range(250, 300)
                                                          : $urandom_range(0, 12);
                        repeat (n)
                        begin
                            ch = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(1, 255))
                                                              : 8'($urandom_range(33, 126));
                            resp_text.push_back(ch);
                        end
                        add_str("\015\n");
                    end
                    3:
                    begin
                        add_str("X-Trace: ");
                        repeat ($urandom_range(0, 8))
                            resp_text.push_back(8'($urandom_range(1, 255)));
                        add_str("\015\n");
                    end
                    4:
                    begin
                        case ($urandom_range(0, 2))
                            0: add_str("WWW-WWW-Authenticate: digest\015\n");
                            1: add_str("\n\nServer: z\015\n");
                            default: add_str("WWWW-AUTHENTICATE:ntlm\015\n");
                        endcase
                    end
                    default: add_str("\015\n");
                endcase
            end

            // broken responses: cut short or ended early by a zero byte
            if ($urandom_range(0, 9) == 0 && resp_text.size() > 1)
            begin
                n = $urandom_range(1, resp_text.size() - 1);
                while (resp_text.size() > n) void'(resp_text.pop_back());
            end
            if ($urandom_range(0, 19) == 0 && resp_text.size() > 0)
            begin
                resp_text[$urandom_range(0, resp_text.size() - 1)] = hrs_pkg::CH_NUL;
            end
            if (resp_text.size() == 0)
            begin
                resp_text.push_back(8'($urandom_range(0, 255)));
            end
            send_response();
            resp_n++;
        end
    endtask

    // main sequence
    initial
    begin
        clear_scan();
        ban_limit = 8'd63;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        test_status_line();
        test_auth_challenges();
        test_server_banner();
        test_zero_byte();
        test_random_traffic();
        wait_idle();
        if (errors == 0)
        begin
            $display("tb_http_response_header_scanner: done, clean");
        end
        else
        begin
            $display("tb_http_response_header_scanner: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
